// ===== design/tpot_pkg.sv =====
// Shared types, constants and helpers for the timed priority override table.
// Used by the table cells, the top level and the port checker.
package tpot_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int PRIO_LEVELS   = 8;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int PRIO_W = 3;
	localparam int RATE_W = 16;
	localparam int TIME_W = 32;
	localparam int DUR_W  = 31;
	localparam int STOP_W = TIME_W + 1;
	localparam int OCNT_W = 5;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [0:0]        REG_DEFAULT_RATE = 1'b0;
	localparam logic [RATE_W-1:0] RATE_RST         = 16'd256;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_RESUME = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t              command;
		logic [PRIO_W-1:0] priority_req;
		logic [RATE_W-1:0] rate;
		logic [DUR_W-1:0]  duration;
		logic              forever_req;
		logic [TIME_W-1:0] now_time;
	} tpot_req_t;

	typedef struct packed {
		logic [RATE_W-1:0] driven_rate;
		logic              rate_written;
		logic              add_dropped;
		logic [OCNT_W-1:0] active_count;
	} tpot_rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [RATE_W-1:0] rate;
		logic [TIME_W-1:0] start;
		logic [STOP_W-1:0] stop;
		logic              no_expiry;
	} slot_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_EXPIRE,
		OP_RESUME,
		OP_PACK,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [PRIO_W-1:0] thr;
		logic [TIME_W-1:0] now;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_MARK,
		ST_PACK,
		ST_SCAN,
		ST_SELECT,
		ST_REPLY
	} state_t;

	function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
		if (int'(p) > PRIO_LEVELS - 1) begin
			return PRIO_W'(PRIO_LEVELS - 1);
		end
		return p;
	endfunction

endpackage

// ===== design/tpot_cell.sv =====
// One entry of the override table, a link in the cell chain.
// Depends on tpot_pkg for the slot and control types.
module tpot_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  tpot_pkg::cell_ctl_t ctl,
	input  logic              load_en,
	input  tpot_pkg::slot_t   new_slot,
	input  logic              nb_valid,
	input  tpot_pkg::slot_t   nb_slot,
	input  logic              hole_in,
	output logic              valid,
	output tpot_pkg::slot_t   slot,
	output logic              hole_out,
	output logic              gap
);
	import tpot_pkg::*;

	logic  valid_q;
	slot_t slot_q;
	logic  take;
	logic  expired;
	logic  retired;

	always_comb begin
		expired = valid_q && !slot_q.no_expiry && ({1'b0, ctl.now} >= slot_q.stop);
		retired = valid_q && (slot_q.prio >= ctl.thr);
		case (ctl.op)
			OP_PACK: begin
				take = hole_in || !valid_q;
			end
			OP_ROTATE: begin
				take = 1'b1;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op) inside
				OP_LOAD: begin
					if (load_en) valid_q <= 1'b1;
				end
				OP_EXPIRE: begin
					if (expired) valid_q <= 1'b0;
				end
				OP_RESUME: begin
					if (retired) valid_q <= 1'b0;
				end
				OP_PACK, OP_ROTATE: begin
					if (take) valid_q <= nb_valid;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD && load_en) begin
			slot_q <= new_slot;
		end else if (take) begin
			slot_q <= nb_slot;
		end
	end

	assign valid    = valid_q;
	assign slot     = slot_q;
	assign hole_out = hole_in || !valid_q;
	assign gap      = hole_in && valid_q;

endmodule

// ===== design/timed_priority_override_table.sv =====
// Timed priority override table: an add passes from ST_ADD to ST_REPLY; a resume marks
// retired entries in ST_MARK and closes them up in ST_PACK before ST_REPLY; a tick marks
// expired entries the same way, then walks the chain in ST_SCAN and picks the rate in
// ST_SELECT. In the chain of entry cells, removed entries are closed up one shift per cycle,
// and a tick walks the whole chain once by rotating it past the head cell, which feeds the
// winner comparison. Depends on tpot_pkg and tpot_cell.
module timed_priority_override_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  tpot_pkg::tpot_req_t         req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output tpot_pkg::tpot_rsp_t         rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpot_pkg::APB_AW-1:0] paddr,
	input  logic [tpot_pkg::APB_DW-1:0] pwdata,
	output logic [tpot_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import tpot_pkg::*;

	state_t state_q, state_d;

	cmd_t              cmd_q;
	logic [PRIO_W-1:0] prio_q;
	logic [RATE_W-1:0] rate_q;
	logic [TIME_W-1:0] now_q;
	logic [STOP_W-1:0] stop_q;
	logic              forever_q;

	logic [CNT_W-1:0]  count_q;
	logic              dropped_q;
	logic              written_q;
	logic [RATE_W-1:0] current_rate_q;
	logic [RATE_W-1:0] default_rate_q;
	logic [IDX_W-1:0]  scan_q;
	logic              have_q;
	logic [PRIO_W-1:0] best_prio_q;
	logic [TIME_W-1:0] best_start_q;
	logic [RATE_W-1:0] best_rate_q;
	tpot_rsp_t         rsp_q;
	logic              rsp_valid_q;

	cell_ctl_t         ctl;
	slot_t             new_slot;
	logic              cell_valid [TABLE_ENTRIES];
	slot_t             cell_slot  [TABLE_ENTRIES];
	logic              nb_valid   [TABLE_ENTRIES];
	slot_t             nb_slot    [TABLE_ENTRIES];
	logic              hole       [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] gap_vec;
	logic [TABLE_ENTRIES-1:0] load_vec;
	logic              any_gap;
	logic [CNT_W-1:0]  cnt_prefix;
	logic              accept;
	logic              reply_go;
	logic              head_better;
	logic              scan_last;
	logic              table_full;
	logic [RATE_W-1:0] target;
	logic              cfg_wr;

	assign accept     = req_valid && req_ready;
	assign reply_go   = (state_q == ST_REPLY) && (!rsp_valid_q || rsp_ready);
	assign any_gap    = |gap_vec;
	assign scan_last  = (scan_q == IDX_W'(TABLE_ENTRIES - 1));
	assign table_full = (count_q == CNT_W'(TABLE_ENTRIES));
	assign target     = have_q ? best_rate_q : default_rate_q;

	assign new_slot.prio      = sat_prio(prio_q);
	assign new_slot.rate      = rate_q;
	assign new_slot.start     = now_q;
	assign new_slot.stop      = stop_q;
	assign new_slot.no_expiry = forever_q;

	assign hole[0] = 1'b0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		assign load_vec[i] = (count_q[IDX_W-1:0] == IDX_W'(i));
		if (i == TABLE_ENTRIES - 1) begin : g_tail
			assign nb_valid[i] = (ctl.op == OP_ROTATE) ? cell_valid[0] : 1'b0;
			assign nb_slot[i]  = cell_slot[0];
		end else begin : g_link
			assign nb_valid[i] = cell_valid[i+1];
			assign nb_slot[i]  = cell_slot[i+1];
		end
		tpot_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.load_en  (load_vec[i]),
			.new_slot (new_slot),
			.nb_valid (nb_valid[i]),
			.nb_slot  (nb_slot[i]),
			.hole_in  (hole[i]),
			.valid    (cell_valid[i]),
			.slot     (cell_slot[i]),
			.hole_out (hole[i+1]),
			.gap      (gap_vec[i])
		);
	end

	always_comb begin
		cnt_prefix = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (cell_valid[i]) cnt_prefix = CNT_W'(i + 1);
		end
	end

	always_comb begin
		head_better = cell_valid[0] && (!have_q || (cell_slot[0].prio < best_prio_q) ||
			((cell_slot[0].prio == best_prio_q) && (cell_slot[0].start > best_start_q)));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (req.command)
						CMD_TICK:   state_d = ST_MARK;
						CMD_RESUME: state_d = ST_MARK;
						CMD_ADD:    state_d = ST_ADD;
						CMD_NONE:   state_d = ST_REPLY;
						default:    state_d = ST_REPLY;
					endcase
				end
			end
			ST_ADD: begin
				state_d = ST_REPLY;
			end
			ST_MARK: begin
				state_d = ST_PACK;
			end
			ST_PACK: begin
				if (!any_gap) state_d = (cmd_q == CMD_TICK) ? ST_SCAN : ST_REPLY;
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_SELECT;
			end
			ST_SELECT: begin
				state_d = ST_REPLY;
			end
			ST_REPLY: begin
				if (!rsp_valid_q || rsp_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		ctl.op    = OP_HOLD;
		ctl.thr   = prio_q;
		ctl.now   = now_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_ADD: begin
				if (!table_full) ctl.op = OP_LOAD;
			end
			ST_MARK: begin
				ctl.op = (cmd_q == CMD_TICK) ? OP_EXPIRE : OP_RESUME;
			end
			ST_PACK: begin
				ctl.op = OP_PACK;
			end
			ST_SCAN: begin
				ctl.op = OP_ROTATE;
			end
			ST_SELECT, ST_REPLY: begin
				ctl.op = OP_HOLD;
			end
			default: begin
				ctl.op = OP_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			dropped_q      <= 1'b0;
			written_q      <= 1'b0;
			have_q         <= 1'b0;
			scan_q         <= '0;
			current_rate_q <= RATE_RST;
			default_rate_q <= RATE_RST;
			rsp_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) default_rate_q <= pwdata[RATE_W-1:0];
			if (accept) begin
				dropped_q <= 1'b0;
				written_q <= 1'b0;
				have_q    <= 1'b0;
				scan_q    <= '0;
			end
			if (state_q == ST_ADD) begin
				if (table_full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (state_q == ST_PACK && !any_gap) count_q <= cnt_prefix;
			if (state_q == ST_SCAN) begin
				scan_q <= scan_q + IDX_W'(1);
				if (head_better) have_q <= 1'b1;
			end
			if (state_q == ST_SELECT && target != current_rate_q) begin
				current_rate_q <= target;
				written_q      <= 1'b1;
			end
			if (reply_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= req.command;
			prio_q    <= req.priority_req;
			rate_q    <= req.rate;
			now_q     <= req.now_time;
			stop_q    <= {1'b0, req.now_time} + STOP_W'(req.duration);
			forever_q <= req.forever_req;
		end
		if (state_q == ST_SCAN && head_better) begin
			best_prio_q  <= cell_slot[0].prio;
			best_start_q <= cell_slot[0].start;
			best_rate_q  <= cell_slot[0].rate;
		end
		if (reply_go) begin
			rsp_q.driven_rate  <= current_rate_q;
			rsp_q.rate_written <= written_q;
			rsp_q.add_dropped  <= dropped_q;
			rsp_q.active_count <= OCNT_W'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[APB_AW-1:2] == REG_DEFAULT_RATE);
	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == REG_DEFAULT_RATE) ?
		APB_DW'(default_rate_q) : '0;

endmodule

// ===== design/tpot_checker.sv =====
// Port-level checker for the timed priority override table, bound to the top level.
// Depends on tpot_pkg for the transaction types and the table size.
module tpot_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input tpot_pkg::tpot_req_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input tpot_pkg::tpot_rsp_t rsp
);
	import tpot_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("Response changed or vanished while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("A new transaction was taken while one was in flight.");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.rate_written && rsp.add_dropped))
		else $error("Rate change and dropped add reported together.");

	a_drop_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.add_dropped |-> rsp.active_count == OCNT_W'(TABLE_ENTRIES))
		else $error("Add dropped while the table was not full.");

endmodule

bind timed_priority_override_table tpot_checker u_tpot_checker (.*);

// ===== bench/tb_timed_priority_override_table.sv =====
// Testbench for the timed priority override table: directed table rows, then random
// add, tick, resume and no-op traffic under several default rates, checked against a queue model.
// Depends on tpot_pkg and the timed_priority_override_table RTL.
module tb_timed_priority_override_table;
	timeunit 1ns;
	timeprecision 1ps;

	import tpot_pkg::*;

	typedef struct {
		logic [PRIO_W-1:0] prio;
		logic [RATE_W-1:0] rate;
		logic [TIME_W-1:0] start;
		logic [STOP_W-1:0] stop;
		logic              no_expiry;
	} held_entry_t;

	typedef struct {
		cmd_t              cmd;
		logic [PRIO_W-1:0] prio;
		logic [RATE_W-1:0] rate;
		logic [DUR_W-1:0]  dur;
		logic              fv;
		logic [TIME_W-1:0] now;
		bit                typed;
		logic [RATE_W-1:0] w_rate;
		logic              w_written;
		logic              w_dropped;
		logic [OCNT_W-1:0] w_count;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	tpot_req_t           req = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	tpot_rsp_t           rsp;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	held_entry_t         held_q[$];
	tpot_rsp_t           pending_rsp[$];
	logic [RATE_W-1:0]   applied_rate = RATE_RST;
	logic [RATE_W-1:0]   fallback_rate = RATE_RST;
	logic [TIME_W-1:0]   sim_now = '0;
	bit                  quiet = 1'b0;
	int                  ready_left = 0;
	int                  sent = 0;
	int                  fail_count = 0;

	dir_row_t directed_rows[] = '{
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'd0,        1'b1, 16'h0100, 1'b0, 1'b0, 5'd0},
		'{CMD_NONE,   3'd7, 16'hFFFF, 31'h7FFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b1, 16'h0100, 1'b0, 1'b0, 5'd0},
		'{CMD_RESUME, 3'd0, 16'h0000, 31'd0,        1'b0, 32'd0,        1'b1, 16'h0100, 1'b0, 1'b0, 5'd0},
		'{CMD_ADD,    3'd7, 16'hFFFF, 31'h7FFFFFFF, 1'b0, 32'hFFFFFFFF, 1'b1, 16'h0100, 1'b0, 1'b0, 5'd1},
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'hFFFFFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b0, 5'd1},
		'{CMD_ADD,    3'd0, 16'h0000, 31'd0,        1'b1, 32'd5,        1'b1, 16'hFFFF, 1'b0, 1'b0, 5'd2},
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'd5,        1'b1, 16'h0000, 1'b1, 1'b0, 5'd2},
		'{CMD_ADD,    3'd0, 16'h1234, 31'd0,        1'b0, 32'd10,       1'b1, 16'h0000, 1'b0, 1'b0, 5'd3},
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'd10,       1'b1, 16'h0000, 1'b0, 1'b0, 5'd2},
		'{CMD_ADD,    3'd0, 16'h0100, 31'd100,      1'b0, 32'd20,       1'b0, '0, '0, '0, '0},
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'd20,       1'b0, '0, '0, '0, '0},
		'{CMD_ADD,    3'd0, 16'h0200, 31'd100,      1'b0, 32'd20,       1'b0, '0, '0, '0, '0},
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'd30,       1'b0, '0, '0, '0, '0},
		'{CMD_ADD,    3'd3, 16'h0300, 31'd0,        1'b1, 32'd40,       1'b0, '0, '0, '0, '0},
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'd119,      1'b0, '0, '0, '0, '0},
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'd120,      1'b0, '0, '0, '0, '0},
		'{CMD_RESUME, 3'd4, 16'h0000, 31'd0,        1'b0, 32'd121,      1'b0, '0, '0, '0, '0},
		'{CMD_RESUME, 3'd0, 16'h0000, 31'd0,        1'b0, 32'd122,      1'b1, 16'h0000, 1'b0, 1'b0, 5'd0},
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'd0,        1'b1, 16'h0100, 1'b1, 1'b0, 5'd0},
		'{CMD_ADD,    3'd5, 16'hABCD, 31'd1,        1'b0, 32'hFFFFFFFF, 1'b0, '0, '0, '0, '0},
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'hFFFFFFFF, 1'b0, '0, '0, '0, '0},
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'd0,        1'b0, '0, '0, '0, '0},
		'{CMD_RESUME, 3'd7, 16'h5555, 31'h2AAAAAAA, 1'b1, 32'd1,        1'b0, '0, '0, '0, '0},
		'{CMD_RESUME, 3'd5, 16'h0000, 31'd0,        1'b0, 32'd2,        1'b0, '0, '0, '0, '0},
		'{CMD_TICK,   3'd0, 16'h0000, 31'd0,        1'b0, 32'd3,        1'b0, '0, '0, '0, '0}
	};

	timed_priority_override_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic tpot_rsp_t apply_command(input tpot_req_t t);
		tpot_rsp_t         r;
		held_entry_t       e;
		int                best;
		logic [RATE_W-1:0] target;
		r = '0;
		case (t.command)
			CMD_ADD: begin
				if (held_q.size() >= TABLE_ENTRIES) begin
					r.add_dropped = 1'b1;
				end else begin
					e.prio = (int'(t.priority_req) > PRIO_LEVELS - 1) ?
						PRIO_W'(PRIO_LEVELS - 1) : t.priority_req;
					e.rate = t.rate;
					e.start = t.now_time;
					e.stop = {1'b0, t.now_time} + {2'b00, t.duration};
					e.no_expiry = t.forever_req;
					held_q.push_back(e);
				end
			end
			CMD_RESUME: begin
				for (int i = held_q.size() - 1; i >= 0; i--)
					if (held_q[i].prio >= t.priority_req)
						held_q.delete(i);
			end
			CMD_TICK: begin
				for (int i = held_q.size() - 1; i >= 0; i--)
					if (!held_q[i].no_expiry && {1'b0, t.now_time} >= held_q[i].stop)
						held_q.delete(i);
				best = 0;
				for (int i = 1; i < held_q.size(); i++)
					if (held_q[i].prio < held_q[best].prio ||
					    (held_q[i].prio == held_q[best].prio &&
					     held_q[i].start > held_q[best].start))
						best = i;
				target = (held_q.size() > 0) ? held_q[best].rate : fallback_rate;
				if (target != applied_rate) begin
					applied_rate = target;
					r.rate_written = 1'b1;
				end
			end
			default: ;
		endcase
		r.driven_rate = applied_rate;
		r.active_count = OCNT_W'(held_q.size());
		return r;
	endfunction

	task automatic flag(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	always @(posedge clk) begin
		tpot_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				flag($sformatf("Unexpected transaction: rate %h written %b dropped %b count %0d",
					rsp.driven_rate, rsp.rate_written, rsp.add_dropped, rsp.active_count));
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.driven_rate !== want.driven_rate || rsp.rate_written !== want.rate_written ||
				    rsp.add_dropped !== want.add_dropped || rsp.active_count !== want.active_count) begin
					flag($sformatf({"Mismatch: expected rate %h written %b dropped %b count %0d,",
						" got rate %h written %b dropped %b count %0d"},
						want.driven_rate, want.rate_written, want.add_dropped, want.active_count,
						rsp.driven_rate, rsp.rate_written, rsp.add_dropped, rsp.active_count));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (quiet) begin
			rsp_ready <= 1'b1;
			ready_left = 0;
		end else if (ready_left > 0) begin
			ready_left--;
		end else if (rsp_ready) begin
			rsp_ready <= 1'b0;
			ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		end else begin
			rsp_ready <= 1'b1;
			ready_left = $urandom_range(0, 20);
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 50) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [TIME_W-1:0] next_now();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			return $urandom;
		end
		if (roll < 5) begin
			sim_now = $urandom;
		end
		sim_now = sim_now + $urandom_range(0, 8);
		return sim_now;
	endfunction

	function automatic tpot_req_t make_item(input cmd_t c);
		tpot_req_t t;
		int        roll;
		t.command = c;
		t.priority_req = PRIO_W'($urandom_range(0, 7));
		roll = $urandom_range(0, 9);
		t.rate = (roll == 0) ? 16'h0000 : (roll == 1) ? fallback_rate :
			(roll == 2) ? 16'hFFFF : 16'($urandom_range(0, 65535));
		roll = $urandom_range(0, 19);
		if (roll == 0) begin
			t.duration = '0;
		end else if (roll == 1) begin
			t.duration = 31'h7FFFFFFF;
		end else if (roll < 4) begin
			t.duration = DUR_W'($urandom);
		end else begin
			t.duration = DUR_W'($urandom_range(1, 60));
		end
		t.forever_req = ($urandom_range(0, 3) == 0);
		t.now_time = next_now();
		return t;
	endfunction

	task automatic send_req(input tpot_req_t t, input bit typed, input tpot_rsp_t want);
		int        gap;
		tpot_rsp_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req <= t;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predicted = apply_command(t);
		pending_rsp.push_back(typed ? want : predicted);
		sent++;
	endtask

	task automatic hold_off();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic drain();
		hold_off();
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [RATE_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_AW'(4 * int'(REG_DEFAULT_RATE));
		pwdata <= APB_DW'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!wr && prdata[RATE_W-1:0] !== value) begin
			flag($sformatf("Register readback: expected %h, got %h", value, prdata[RATE_W-1:0]));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_default_rate(input logic [RATE_W-1:0] value);
		drain();
		apb_access(1'b1, value);
		fallback_rate = value;
		apb_access(1'b0, value);
	endtask

	task automatic run_random(input int count);
		int        stop_at;
		int        roll;
		tpot_req_t t;
		cmd_t      c;
		stop_at = sent + count;
		while (sent < stop_at) begin
			case ($urandom_range(0, 19))
				0: begin
					while (held_q.size() < TABLE_ENTRIES)
						send_req(make_item(CMD_ADD), 1'b0, '0);
					repeat ($urandom_range(1, 3)) send_req(make_item(CMD_ADD), 1'b0, '0);
					send_req(make_item(CMD_TICK), 1'b0, '0);
				end
				1, 2: begin
					t = make_item(CMD_ADD);
					t.rate = '0;
					t.forever_req = 1'b1;
					send_req(t, 1'b0, '0);
					repeat ($urandom_range(1, 4)) send_req(make_item(CMD_TICK), 1'b0, '0);
					c = CMD_RESUME;
					t.command = c;
					t.priority_req = PRIO_W'($urandom_range(0, int'(t.priority_req)));
					t.now_time = next_now();
					send_req(t, 1'b0, '0);
				end
				3: begin
					if ($urandom_range(0, 3) == 0) begin
						drain();
					end
				end
				default: begin
					repeat ($urandom_range(1, 10)) begin
						roll = $urandom_range(0, 99);
						c = (roll < 40) ? CMD_ADD : (roll < 80) ? CMD_TICK :
							(roll < 93) ? CMD_RESUME : CMD_NONE;
						send_req(make_item(c), 1'b0, '0);
					end
				end
			endcase
		end
	endtask

	initial begin
		tpot_req_t t;
		tpot_rsp_t want;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			t.command = directed_rows[i].cmd;
			t.priority_req = directed_rows[i].prio;
			t.rate = directed_rows[i].rate;
			t.duration = directed_rows[i].dur;
			t.forever_req = directed_rows[i].fv;
			t.now_time = directed_rows[i].now;
			want.driven_rate = directed_rows[i].w_rate;
			want.rate_written = directed_rows[i].w_written;
			want.add_dropped = directed_rows[i].w_dropped;
			want.active_count = directed_rows[i].w_count;
			send_req(t, directed_rows[i].typed, want);
		end

		set_default_rate(16'hFFFF);
		run_random(250);
		set_default_rate(16'h0000);
		run_random(250);
		set_default_rate(16'($urandom_range(0, 65535)));
		quiet = 1'b1;
		run_random(250);
		quiet = 1'b0;
		set_default_rate(16'($urandom_range(0, 65535)));
		run_random(250);
		set_default_rate(RATE_RST);
		run_random(250);

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending_rsp.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== timed_priority_override_table.f =====
design/tpot_pkg.sv
design/tpot_cell.sv
design/timed_priority_override_table.sv
design/tpot_checker.sv
bench/tb_timed_priority_override_table.sv
